/* rtl/core/cti_pkg.sv */
// ----------------------------------------------------------------------------
// cti_pkg
// Shared constants, command and status types and helpers of the cubic table
// interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int FRAC_BITS   = 12;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    localparam int LEVEL_W = 16;
    localparam int POS_W   = 22;
    localparam int INT_W   = POS_W - FRAC_BITS;
    localparam int TSIZE_W = 11;
    localparam int PH_W    = 13;
    localparam int Y_W     = 17;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int IDX_LSB   = 0;
    localparam int VAL_LSB   = 10;
    localparam int POS_LSB   = 26;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 3'd4;

    localparam logic KIND_CATMULL = 1'b0;
    localparam logic KIND_BSPLINE = 1'b1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [TSIZE_W-1:0]        RST_TABLE_SIZE  = 11'd1024;
    localparam logic signed [LEVEL_W-1:0] RST_DB_LOW      = -16'sd18432;
    localparam logic signed [LEVEL_W-1:0] RST_DB_HIGH     = 16'sd6144;
    localparam logic [PH_W-1:0]           RST_PLOT_HEIGHT = 13'd100;
    localparam logic [PH_W-1:0]           MAX_PLOT_HEIGHT = 13'd4096;

    // Datapath word widths of the Horner evaluation.
    localparam int COEF_W = 21;
    localparam int T_W    = FRAC_BITS + 1;
    localparam int S1_W   = COEF_W + T_W;
    localparam int S2_W   = S1_W + FRAC_BITS;
    localparam int S3_W   = S2_W - FRAC_BITS;
    localparam int S4_W   = S3_W + T_W;
    localparam int Q_W    = S4_W - 2 * FRAC_BITS - 1;

    localparam logic signed [S2_W-1:0] HALF_T = S2_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [S4_W-1:0] CR_RND = S4_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [S4_W-1:0] BS_RND = S4_W'(3) << (2 * FRAC_BITS);

    // Floor division by three through a reciprocal on an offset operand.
    localparam int D3_U_W   = 19;
    localparam int D3_R_W   = 20;
    localparam int D3_SHIFT = 21;
    localparam int D3_P_W   = D3_U_W + D3_R_W;
    localparam int D3_Q_W   = D3_P_W - D3_SHIFT;
    localparam logic [D3_R_W-1:0]     D3_RECIP   = 20'd699051;
    localparam logic signed [Q_W-1:0] D3_OFFSET  = 22'sd196608;
    localparam logic signed [Q_W-1:0] D3_BIAS    = 22'sd65536;
    localparam logic signed [Q_W-1:0] D3_CLP_MAX = 22'sd131071;
    localparam logic signed [Q_W-1:0] D3_CLP_MIN = -22'sd131072;

    localparam logic signed [Q_W-1:0] Q78_MAX = 22'sd32767;
    localparam logic signed [Q_W-1:0] Q78_MIN = -22'sd32768;

    // Plot mapping divider.
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 17;
    localparam int DIV_STEPS = Y_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic       mem_we;
        logic       pos_load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       coef_en;
        logic       hor1_en;
        logic       hor2_en;
        logic       hor3_en;
        logic       hor4_en;
        logic       div3_en;
        logic       ymap_en;
        logic       div_start;
        logic       out_load;
    } cti_cmd_t;

    typedef struct packed {
        logic div_busy;
    } cti_sts_t;

    function automatic logic signed [LEVEL_W-1:0] sat_q78(input logic signed [Q_W-1:0] x);
        logic signed [Q_W-1:0] c;
        begin
            if (x > Q78_MAX) begin
                c = Q78_MAX;
            end else if (x < Q78_MIN) begin
                c = Q78_MIN;
            end else begin
                c = x;
            end
            sat_q78 = c[LEVEL_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cti_div.sv */
// ----------------------------------------------------------------------------
// cti_div
// Restoring divider for the plot mapping, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [cti_pkg::NUM_W-1:0]     dividend,
    input  wire logic [cti_pkg::DEN_W-1:0]     divisor,
    output logic                               busy,
    output logic [cti_pkg::Y_W-1:0]            quotient
);

    localparam int REM_W = cti_pkg::DEN_W;
    localparam int HI_W  = cti_pkg::NUM_W - cti_pkg::DIV_STEPS;

    logic                              busy_reg, busy_next;
    logic [cti_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]                  rem_reg, rem_next;
    logic [cti_pkg::Y_W-1:0]           sh_reg, sh_next;
    logic [REM_W:0]                    trial;
    logic                              fits;

    // The quotient is known to fit in Y_W bits, so the upper dividend bits
    // already stand below the divisor and seed the remainder.
    assign trial = {rem_reg, sh_reg[cti_pkg::Y_W-1]};
    assign fits  = (trial >= {1'b0, divisor});

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = cti_pkg::DIV_CNT_W'(cti_pkg::DIV_STEPS);
            rem_next  = REM_W'(dividend[cti_pkg::NUM_W-1 -: HI_W]);
            sh_next   = dividend[cti_pkg::Y_W-1:0];
        end else if (busy_reg) begin
            rem_next = fits ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
            sh_next  = {sh_reg[cti_pkg::Y_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cti_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign busy     = busy_reg;
    assign quotient = sh_reg;

endmodule

`default_nettype wire

/* rtl/core/cti_datapath.sv */
// ----------------------------------------------------------------------------
// cti_datapath
// Level table, configuration registers, cubic evaluation and plot mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_datapath (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire cti_pkg::cti_cmd_t                  cmd,
    output cti_pkg::cti_sts_t                       sts,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cti_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic [cti_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic [cti_pkg::M_TDATA_W-1:0]           m_tdata
);

    localparam int AW = cti_pkg::ADDR_W;
    localparam int LW = cti_pkg::LEVEL_W;
    localparam int CW = cti_pkg::COEF_W;
    localparam int FB = cti_pkg::FRAC_BITS;

    // Configuration registers.
    logic                          kind_reg;
    logic [cti_pkg::TSIZE_W-1:0]   tsize_reg;
    logic signed [LW-1:0]          db_low_reg;
    logic signed [LW-1:0]          db_high_reg;
    logic [cti_pkg::PH_W-1:0]      pheight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg    <= cti_pkg::KIND_CATMULL;
            tsize_reg   <= cti_pkg::RST_TABLE_SIZE;
            db_low_reg  <= cti_pkg::RST_DB_LOW;
            db_high_reg <= cti_pkg::RST_DB_HIGH;
            pheight_reg <= cti_pkg::RST_PLOT_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                cti_pkg::CFG_INTERP_KIND: kind_reg    <= cfg_wdata[0];
                cti_pkg::CFG_TABLE_SIZE:  tsize_reg   <= cfg_wdata[cti_pkg::TSIZE_W-1:0];
                cti_pkg::CFG_DB_LOW:      db_low_reg  <= $signed(cfg_wdata);
                cti_pkg::CFG_DB_HIGH:     db_high_reg <= $signed(cfg_wdata);
                cti_pkg::CFG_PLOT_HEIGHT: pheight_reg <= cfg_wdata[cti_pkg::PH_W-1:0];
                default: ;
            endcase
        end
    end

    // Level table.
    logic [LW-1:0]  level_mem [0:cti_pkg::TABLE_DEPTH-1];
    logic [LW-1:0]  rd_data_reg;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    assign wr_addr = s_tdata[cti_pkg::IDX_LSB +: AW];

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            level_mem[wr_addr] <= s_tdata[cti_pkg::VAL_LSB +: LW];
        end
        if (cmd.rd_en) begin
            rd_data_reg <= level_mem[rd_addr];
        end
    end

    // Neighbour addresses.
    logic [cti_pkg::POS_W-1:0]     pos_reg;
    logic [cti_pkg::INT_W-1:0]     pos_int;
    logic [cti_pkg::TSIZE_W-1:0]   tsize_m1;
    logic [AW-1:0]                 size_m1;
    logic [AW-1:0]                 i0, i1, i2, i3;
    logic [AW:0]                   i1p1, i1p2;

    always_ff @(posedge aclk) begin
        if (cmd.pos_load) begin
            pos_reg <= s_tdata[cti_pkg::POS_LSB +: cti_pkg::POS_W];
        end
    end

    assign pos_int  = pos_reg[cti_pkg::POS_W-1:FB];
    assign tsize_m1 = tsize_reg - 1'b1;

    always_comb begin
        if (tsize_reg == '0) begin
            size_m1 = '0;
        end else if (tsize_reg > cti_pkg::TSIZE_W'(cti_pkg::TABLE_DEPTH)) begin
            size_m1 = AW'(cti_pkg::TABLE_DEPTH - 1);
        end else begin
            size_m1 = tsize_m1[AW-1:0];
        end
        i1   = (AW'(pos_int) > size_m1) ? size_m1 : AW'(pos_int);
        i0   = (i1 != '0) ? i1 - 1'b1 : '0;
        i1p1 = {1'b0, i1} + (AW+1)'(1);
        i1p2 = {1'b0, i1} + (AW+1)'(2);
        i2   = (i1p1 > {1'b0, size_m1}) ? size_m1 : i1p1[AW-1:0];
        i3   = (i1p2 > {1'b0, size_m1}) ? size_m1 : i1p2[AW-1:0];
        case (cmd.rd_sel)
            2'd0:    rd_addr = i0;
            2'd1:    rd_addr = i1;
            2'd2:    rd_addr = i2;
            default: rd_addr = i3;
        endcase
    end

    // Neighbour values.
    logic signed [LW-1:0] p_reg [0:3];

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            p_reg[cmd.cap_sel] <= $signed(rd_data_reg);
        end
    end

    // Cubic coefficients.
    logic signed [CW-1:0] pe0, pe1, pe2, pe3;
    logic signed [CW-1:0] k0_reg, k1_reg, k2_reg, k3_reg;
    logic signed [CW-1:0] k0_next, k1_next, k2_next, k3_next;

    assign pe0 = CW'(p_reg[0]);
    assign pe1 = CW'(p_reg[1]);
    assign pe2 = CW'(p_reg[2]);
    assign pe3 = CW'(p_reg[3]);

    always_comb begin
        if (kind_reg == cti_pkg::KIND_BSPLINE) begin
            k0_next = pe0 + (pe1 <<< 2) + pe2;
            k1_next = (pe2 - pe0) * 21'sd3;
            k2_next = (pe0 + pe2) * 21'sd3 - pe1 * 21'sd6;
            k3_next = pe3 - pe0 + (pe1 - pe2) * 21'sd3;
        end else begin
            k0_next = pe1 <<< 1;
            k1_next = pe2 - pe0;
            k2_next = (pe0 <<< 1) - pe1 * 21'sd5 + (pe2 <<< 2) - pe3;
            k3_next = pe3 - pe0 + (pe1 - pe2) * 21'sd3;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.coef_en) begin
            k0_reg <= k0_next;
            k1_reg <= k1_next;
            k2_reg <= k2_next;
            k3_reg <= k3_next;
        end
    end

    // Horner evaluation, one multiplication per step.
    logic signed [cti_pkg::T_W-1:0]  t_s;
    logic signed [cti_pkg::S1_W-1:0] prod1, s1_reg;
    logic signed [cti_pkg::S2_W-1:0] prod2, s2_sum;
    logic signed [cti_pkg::S3_W-1:0] s3_reg;
    logic signed [cti_pkg::S4_W-1:0] prod3, s4_reg;

    assign t_s    = $signed({1'b0, pos_reg[FB-1:0]});
    assign prod1  = k3_reg * t_s;
    assign prod2  = s1_reg * t_s;
    assign s2_sum = prod2 + (cti_pkg::S2_W'(k1_reg) <<< (2 * FB)) + cti_pkg::HALF_T;
    assign prod3  = s3_reg * t_s;

    always_ff @(posedge aclk) begin
        if (cmd.hor1_en) begin
            s1_reg <= prod1 + (cti_pkg::S1_W'(k2_reg) <<< FB);
        end
        if (cmd.hor2_en) begin
            s3_reg <= $signed(s2_sum[cti_pkg::S2_W-1:FB]);
        end
        if (cmd.hor3_en) begin
            s4_reg <= prod3 + (cti_pkg::S4_W'(k0_reg) <<< (2 * FB));
        end
    end

    // Final scaling: a shift for Catmull-Rom, a further floor division by
    // three for the B-spline.
    logic signed [cti_pkg::S4_W-1:0]   r_cr, r_bs;
    logic signed [cti_pkg::Q_W-1:0]    q_cr, q_bs, q_clp, u_w;
    logic signed [LW-1:0]              vcr_reg;
    logic [cti_pkg::D3_U_W-1:0]        u_reg;
    logic [cti_pkg::D3_P_W-1:0]        d3_prod;
    logic [cti_pkg::D3_Q_W-1:0]        d3_quo;
    logic signed [cti_pkg::Q_W-1:0]    vb_w;
    logic signed [LW-1:0]              v_reg;

    assign r_cr = s4_reg + cti_pkg::CR_RND;
    assign r_bs = s4_reg + cti_pkg::BS_RND;
    assign q_cr = $signed(r_cr[cti_pkg::S4_W-1:2*FB+1]);
    assign q_bs = $signed(r_bs[cti_pkg::S4_W-1:2*FB+1]);

    always_comb begin
        if (q_bs > cti_pkg::D3_CLP_MAX) begin
            q_clp = cti_pkg::D3_CLP_MAX;
        end else if (q_bs < cti_pkg::D3_CLP_MIN) begin
            q_clp = cti_pkg::D3_CLP_MIN;
        end else begin
            q_clp = q_bs;
        end
    end

    assign u_w     = q_clp + cti_pkg::D3_OFFSET;
    assign d3_prod = cti_pkg::D3_P_W'(u_reg) * cti_pkg::D3_P_W'(cti_pkg::D3_RECIP);
    assign d3_quo  = d3_prod[cti_pkg::D3_P_W-1:cti_pkg::D3_SHIFT];
    assign vb_w    = $signed(cti_pkg::Q_W'(d3_quo)) - cti_pkg::D3_BIAS;

    always_ff @(posedge aclk) begin
        if (cmd.hor4_en) begin
            vcr_reg <= cti_pkg::sat_q78(q_cr);
            u_reg   <= u_w[cti_pkg::D3_U_W-1:0];
        end
        if (cmd.div3_en) begin
            v_reg <= (kind_reg == cti_pkg::KIND_BSPLINE) ? cti_pkg::sat_q78(vb_w) : vcr_reg;
        end
    end

    // Plot mapping.
    logic signed [LW:0]              diff_hv, den_hl;
    logic [cti_pkg::PH_W-1:0]        h_eff;
    logic [cti_pkg::Y_W-1:0]         y_full;
    logic                            empty_rng, at_top, at_bot;
    logic [LW+cti_pkg::PH_W-1:0]     prod_y;
    logic [cti_pkg::NUM_W-1:0]       num_reg;
    logic [cti_pkg::DEN_W-1:0]       den2_reg;
    logic                            spec_reg;
    logic [cti_pkg::Y_W-1:0]         spec_val_reg;
    logic [cti_pkg::Y_W-1:0]         quotient;
    logic [cti_pkg::Y_W-1:0]         y_sel;
    logic [cti_pkg::M_TDATA_W-1:0]   out_data_reg;

    assign diff_hv   = (LW+1)'(db_high_reg) - (LW+1)'(v_reg);
    assign den_hl    = (LW+1)'(db_high_reg) - (LW+1)'(db_low_reg);
    assign h_eff     = (pheight_reg > cti_pkg::MAX_PLOT_HEIGHT) ? cti_pkg::MAX_PLOT_HEIGHT
                                                                 : pheight_reg;
    assign y_full    = {h_eff, 4'b0000};
    assign empty_rng = (db_high_reg <= db_low_reg);
    assign at_top    = (v_reg >= db_high_reg);
    assign at_bot    = (v_reg <= db_low_reg);
    assign prod_y    = (LW+cti_pkg::PH_W)'(diff_hv[LW-1:0]) * (LW+cti_pkg::PH_W)'(h_eff);

    always_ff @(posedge aclk) begin
        if (cmd.ymap_en) begin
            num_reg      <= {prod_y[LW+cti_pkg::PH_W-2:0], 5'b00000}
                            + cti_pkg::NUM_W'(den_hl[LW-1:0]);
            den2_reg     <= {den_hl[LW-1:0], 1'b0};
            spec_reg     <= empty_rng | at_top | at_bot;
            spec_val_reg <= (empty_rng | at_top) ? '0 : y_full;
        end
    end

    cti_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num_reg),
        .divisor  (den2_reg),
        .busy     (sts.div_busy),
        .quotient (quotient)
    );

    assign y_sel = spec_reg ? spec_val_reg : quotient;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= {7'b0000000, y_sel, v_reg};
        end
    end

    assign m_tdata = out_data_reg;

endmodule

`default_nettype wire

/* rtl/core/cti_ctrl.sv */
// ----------------------------------------------------------------------------
// cti_ctrl
// Sequencer of the interpolator: handshakes, table reads and datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output cti_pkg::cti_cmd_t       cmd,
    input  wire cti_pkg::cti_sts_t  sts
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_RD2    = 4'd3;
    localparam logic [3:0] ST_RD3    = 4'd4;
    localparam logic [3:0] ST_RD4    = 4'd5;
    localparam logic [3:0] ST_COEF   = 4'd6;
    localparam logic [3:0] ST_HOR1   = 4'd7;
    localparam logic [3:0] ST_HOR2   = 4'd8;
    localparam logic [3:0] ST_HOR3   = 4'd9;
    localparam logic [3:0] ST_HOR4   = 4'd10;
    localparam logic [3:0] ST_DIV3   = 4'd11;
    localparam logic [3:0] ST_YMAP   = 4'd12;
    localparam logic [3:0] ST_DSTART = 4'd13;
    localparam logic [3:0] ST_DWAIT  = 4'd14;
    localparam logic [3:0] ST_OUT    = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == cti_pkg::MODE_QUERY) begin
                        cmd.pos_load = 1'b1;
                        state_next   = ST_RD0;
                    end else begin
                        cmd.mem_we = 1'b1;
                    end
                end
            end
            ST_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd1;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd0;
                state_next  = ST_RD2;
            end
            ST_RD2: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd2;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd1;
                state_next  = ST_RD3;
            end
            ST_RD3: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = 2'd3;
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd2;
                state_next  = ST_RD4;
            end
            ST_RD4: begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd3;
                state_next  = ST_COEF;
            end
            ST_COEF: begin
                cmd.coef_en = 1'b1;
                state_next  = ST_HOR1;
            end
            ST_HOR1: begin
                cmd.hor1_en = 1'b1;
                state_next  = ST_HOR2;
            end
            ST_HOR2: begin
                cmd.hor2_en = 1'b1;
                state_next  = ST_HOR3;
            end
            ST_HOR3: begin
                cmd.hor3_en = 1'b1;
                state_next  = ST_HOR4;
            end
            ST_HOR4: begin
                cmd.hor4_en = 1'b1;
                state_next  = ST_DIV3;
            end
            ST_DIV3: begin
                cmd.div3_en = 1'b1;
                state_next  = ST_YMAP;
            end
            ST_YMAP: begin
                cmd.ymap_en = 1'b1;
                state_next  = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (!sts.div_busy) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

/* rtl/core/cubic_table_interpolator_to_plot_y.sv */
// ----------------------------------------------------------------------------
// cubic_table_interpolator_to_plot_y
// Level table with Catmull-Rom or cubic B-spline interpolation and mapping
// of the interpolated level to a plot y coordinate.
//
// Channel   Direction  Payload
// s_        in         tdata: entry_index, entry_value, query_position;
//                      tuser: mode
// m_        out        tdata: interp_value, y_pos
// cfg_      in         cfg_index selects the register, cfg_wdata the value
//
// A write beat goes straight into the table and the block stays ready. A query
// runs from beat to beat through four reads of the table, the Horner steps,
// and the restoring divider of the y mapping.
// The result waits in the output register, so a new beat is taken while it
// is stalled; the next query then holds in its last step until it drains.
// Reset is synchronous and active low; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_table_interpolator_to_plot_y (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // entry_index [9:0], entry_value [25:10], query_position [47:26]
    input  wire logic [cti_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode [0]
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // interp_value [15:0], y_pos [32:16], zero [39:33]
    output logic [cti_pkg::M_TDATA_W-1:0]          m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [cti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cti_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    cti_pkg::cti_cmd_t cmd;
    cti_pkg::cti_sts_t sts;

    cti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    cti_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == cti_pkg::MODE_WRITE && !m_tvalid) |=> !m_tvalid)
        else $error("write beat produced a result");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == cti_pkg::MODE_QUERY) |=> !s_tready)
        else $error("input taken while a query is in progress");

    a_y_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[32:16] <= 17'd65536))
        else $error("y_pos beyond the plot height");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:33] == 7'd0))
        else $error("padding bits of the result beat are not zero");

endmodule

`default_nettype wire

/* tb/tb_cubic_table_interpolator_to_plot_y.sv */
// ----------------------------------------------------------------------------
// tb_cubic_table_interpolator_to_plot_y
// Self-checking testbench of the cubic table interpolator. Directed beats hit
// the extreme levels, both interpolation kinds, table size clamping and the
// plot range corners. Then the whole table is loaded and random mixes of
// writes and queries run under many register settings. A predictor mirrors
// the table and registers and queues the expected level and plot y of each
// query; every result beat is checked against the oldest entry.
// ----------------------------------------------------------------------------
module tb_cubic_table_interpolator_to_plot_y;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic signed [cti_pkg::LEVEL_W-1:0] level;
        logic [cti_pkg::Y_W-1:0]            y;
    } plot_point_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cti_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cti_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           cfg_wr_en = 1'b0;
    logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cti_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    logic signed [cti_pkg::LEVEL_W-1:0] shadow_levels [0:cti_pkg::TABLE_DEPTH-1];
    logic                               pr_kind = cti_pkg::KIND_CATMULL;
    logic [cti_pkg::TSIZE_W-1:0]        pr_size = cti_pkg::RST_TABLE_SIZE;
    logic signed [cti_pkg::LEVEL_W-1:0] pr_lo = cti_pkg::RST_DB_LOW;
    logic signed [cti_pkg::LEVEL_W-1:0] pr_hi = cti_pkg::RST_DB_HIGH;
    logic [cti_pkg::PH_W-1:0]           pr_height = cti_pkg::RST_PLOT_HEIGHT;

    plot_point_t expected_points[$];
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b1;

    cubic_table_interpolator_to_plot_y dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic logic signed [cti_pkg::LEVEL_W-1:0] interp_at(
        input logic [cti_pkg::POS_W-1:0] pos);
        longint one, last, ip, i0, i2, i3, t, p0, p1, p2, p3;
        longint c0, c1, c2, c3, scale, acc;
        one = longint'(1) << cti_pkg::FRAC_BITS;
        if (pr_size == 0) begin
            last = 0;
        end else if (pr_size > cti_pkg::TABLE_DEPTH) begin
            last = cti_pkg::TABLE_DEPTH - 1;
        end else begin
            last = longint'(pr_size) - 1;
        end
        t = longint'(pos) & (one - 1);
        ip = longint'(pos) >> cti_pkg::FRAC_BITS;
        if (ip > last) begin
            ip = last;
        end
        i0 = (ip > 0) ? ip - 1 : 0;
        i2 = (ip + 1 > last) ? last : ip + 1;
        i3 = (ip + 2 > last) ? last : ip + 2;
        p0 = shadow_levels[i0];
        p1 = shadow_levels[ip];
        p2 = shadow_levels[i2];
        p3 = shadow_levels[i3];
        if (pr_kind == cti_pkg::KIND_CATMULL) begin
            c0 = 2 * p1;
            c1 = p2 - p0;
            c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
            c3 = (p3 - p0) + 3 * (p1 - p2);
            scale = 2;
        end else begin
            c0 = p0 + 4 * p1 + p2;
            c1 = 3 * (p2 - p0);
            c2 = 3 * p0 - 6 * p1 + 3 * p2;
            c3 = -p0 + 3 * p1 - 3 * p2 + p3;
            scale = 6;
        end
        acc = (c3 * t + c2 * one) * t + c1 * one * one;
        acc = floor_quot(acc + one / 2, one);
        acc = acc * t + c0 * one * one;
        acc = floor_quot(acc + scale * one * one / 2, scale * one * one);
        if (acc > 32767) begin
            acc = 32767;
        end
        if (acc < -32768) begin
            acc = -32768;
        end
        return cti_pkg::LEVEL_W'(acc);
    endfunction

    function automatic logic [cti_pkg::Y_W-1:0] plot_y_of(
        input logic signed [cti_pkg::LEVEL_W-1:0] lvl);
        longint lo, hi, h, v, num, den;
        lo = pr_lo;
        hi = pr_hi;
        v = lvl;
        h = (pr_height > cti_pkg::MAX_PLOT_HEIGHT) ? longint'(cti_pkg::MAX_PLOT_HEIGHT)
                                                   : longint'(pr_height);
        if (hi <= lo || v >= hi) begin
            return '0;
        end
        if (v <= lo) begin
            return cti_pkg::Y_W'(h * 16);
        end
        num = (hi - v) * h * 16;
        den = hi - lo;
        return cti_pkg::Y_W'((num * 2 + den) / (den * 2));
    endfunction

    function automatic logic signed [cti_pkg::LEVEL_W-1:0] random_level();
        if ($urandom_range(0, 15) == 0) begin
            return cti_pkg::LEVEL_W'($urandom);
        end
        return cti_pkg::LEVEL_W'(int'($urandom_range(0, 30000)) - 24000);
    endfunction

    task automatic write_reg(input logic [cti_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cti_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            cti_pkg::CFG_INTERP_KIND: pr_kind = val[0];
            cti_pkg::CFG_TABLE_SIZE:  pr_size = val[cti_pkg::TSIZE_W-1:0];
            cti_pkg::CFG_DB_LOW:      pr_lo = val;
            cti_pkg::CFG_DB_HIGH:     pr_hi = val;
            cti_pkg::CFG_PLOT_HEIGHT: pr_height = val[cti_pkg::PH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Leaves s_tvalid high after the beat; the next send or settle moves it.
    task automatic send_beat(input logic mode, input logic [cti_pkg::ADDR_W-1:0] idx,
                             input logic [cti_pkg::LEVEL_W-1:0] val,
                             input logic [cti_pkg::POS_W-1:0] pos);
        int          gap;
        plot_point_t pt;
        gap = 0;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {pos, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (mode == cti_pkg::MODE_QUERY) begin
            pt.level = interp_at(pos);
            pt.y = plot_y_of(pt.level);
            expected_points.push_back(pt);
        end else begin
            shadow_levels[idx] = val;
        end
    endtask

    task automatic send_query(input logic [cti_pkg::POS_W-1:0] pos);
        send_beat(cti_pkg::MODE_QUERY, cti_pkg::ADDR_W'($urandom),
                  cti_pkg::LEVEL_W'($urandom), pos);
    endtask

    task automatic send_write(input logic [cti_pkg::ADDR_W-1:0] idx,
                              input logic [cti_pkg::LEVEL_W-1:0] val);
        send_beat(cti_pkg::MODE_WRITE, idx, val, cti_pkg::POS_W'($urandom));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_level_extremes();
        settle();
        write_reg(cti_pkg::CFG_TABLE_SIZE, 16'd4);
        write_reg(cti_pkg::CFG_INTERP_KIND, 16'(cti_pkg::KIND_CATMULL));
        send_write(10'd0, 16'sd32767);
        send_write(10'd1, -16'sd32768);
        send_write(10'd2, 16'sd32767);
        send_write(10'd3, -16'sd32768);
        send_write(10'd1023, 16'sh1234);
        send_query('0);
        send_query({10'd1, 12'h800});
        send_query({10'd2, 12'hFFF});
        send_query('1);
        settle();
        write_reg(cti_pkg::CFG_INTERP_KIND, 16'(cti_pkg::KIND_BSPLINE));
        send_query('0);
        send_query({10'd1, 12'h800});
        send_query({10'd2, 12'hFFF});
        send_query('1);
    endtask

    task automatic test_size_clamp();
        settle();
        write_reg(cti_pkg::CFG_TABLE_SIZE, 16'd0);
        send_query({10'd2, 12'h400});
        settle();
        write_reg(cti_pkg::CFG_TABLE_SIZE, 16'd2047);
        send_query({10'd1, 12'h123});
        settle();
        write_reg(cti_pkg::CFG_TABLE_SIZE, 16'd1);
        send_query('1);
    endtask

    task automatic test_plot_range();
        settle();
        write_reg(cti_pkg::CFG_TABLE_SIZE, 16'd4);
        write_reg(cti_pkg::CFG_INTERP_KIND, 16'(cti_pkg::KIND_CATMULL));
        write_reg(cti_pkg::CFG_DB_LOW, 16'(-32768));
        write_reg(cti_pkg::CFG_DB_HIGH, 16'd32767);
        write_reg(cti_pkg::CFG_PLOT_HEIGHT, 16'd4096);
        send_write(10'd0, -16'sd256);
        send_write(10'd1, 16'sd0);
        send_write(10'd2, 16'sd2560);
        send_write(10'd3, -16'sd5120);
        send_query({10'd1, 12'h800});
        settle();
        write_reg(cti_pkg::CFG_PLOT_HEIGHT, 16'd8191);
        send_query({10'd1, 12'h400});
        settle();
        write_reg(cti_pkg::CFG_PLOT_HEIGHT, 16'd0);
        send_query({10'd1, 12'h400});
        settle();
        write_reg(cti_pkg::CFG_PLOT_HEIGHT, 16'd100);
        write_reg(cti_pkg::CFG_DB_LOW, 16'(-256));
        write_reg(cti_pkg::CFG_DB_HIGH, 16'd0);
        send_query({10'd1, 12'h000});
        send_query({10'd0, 12'h000});
        settle();
        write_reg(cti_pkg::CFG_DB_LOW, 16'd0);
        send_query({10'd2, 12'h200});
    endtask

    task automatic test_table_fill();
        settle();
        for (int k = 0; k < cti_pkg::TABLE_DEPTH; k++) begin
            send_write(cti_pkg::ADDR_W'(k), random_level());
        end
    endtask

    task automatic test_random_traffic(input int phases, input int per_phase, input bit idling);
        int sz, lo, hi, ht, ip_top;
        idle_on = idling;
        for (int ph = 0; ph < phases; ph++) begin
            settle();
            write_reg(cti_pkg::CFG_INTERP_KIND, 16'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0: sz = 0;
                1: sz = 1;
                2: sz = $urandom_range(2, 4);
                3: sz = 1024;
                4: sz = $urandom_range(1025, 2047);
                default: sz = $urandom_range(5, 1023);
            endcase
            write_reg(cti_pkg::CFG_TABLE_SIZE, 16'(sz));
            case ($urandom_range(0, 7))
                0: begin
                    lo = -32768;
                    hi = 32767;
                end
                1: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = lo - int'($urandom_range(0, 200));
                    if (hi < -32768) begin
                        hi = -32768;
                    end
                end
                2: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = int'($urandom_range(0, 65535)) - 32768;
                end
                default: begin
                    lo = int'($urandom_range(0, 24000)) - 24000;
                    hi = lo + int'($urandom_range(1, 30000));
                end
            endcase
            write_reg(cti_pkg::CFG_DB_LOW, 16'(lo));
            write_reg(cti_pkg::CFG_DB_HIGH, 16'(hi));
            case ($urandom_range(0, 11))
                0: ht = 0;
                1: ht = 1;
                2: ht = 4096;
                3: ht = $urandom_range(4097, 8191);
                default: ht = $urandom_range(2, 4095);
            endcase
            write_reg(cti_pkg::CFG_PLOT_HEIGHT, 16'(ht));
            ip_top = (sz == 0) ? 1 : (sz > 1023 ? 1023 : sz);
            for (int k = 0; k < per_phase; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_write(cti_pkg::ADDR_W'($urandom), random_level());
                end else if ($urandom_range(0, 3) == 0) begin
                    send_query(cti_pkg::POS_W'($urandom));
                end else begin
                    send_query({cti_pkg::ADDR_W'($urandom_range(0, ip_top)),
                                cti_pkg::FRAC_BITS'($urandom)});
                end
            end
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        plot_point_t                        want;
        logic signed [cti_pkg::LEVEL_W-1:0] got_level;
        logic [cti_pkg::Y_W-1:0]            got_y;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_level = m_tdata[cti_pkg::LEVEL_W-1:0];
                got_y = m_tdata[cti_pkg::LEVEL_W +: cti_pkg::Y_W];
                if (expected_points.size() == 0) begin
                    $error("result beat with no query pending: interp_value %0d, y_pos %0d",
                           got_level, got_y);
                    fail_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (got_level !== want.level) begin
                        $error("interp_value: expected %0d, got %0d", want.level, got_level);
                        fail_count++;
                    end
                    if (got_y !== want.y) begin
                        $error("y_pos: expected %0d, got %0d", want.y, got_y);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_level_extremes();
        test_size_clamp();
        test_plot_range();
        test_table_fill();
        test_random_traffic(15, 50, 1'b1);
        test_random_traffic(3, 50, 1'b0);
        settle();
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/cti_pkg.sv
rtl/core/cti_div.sv
rtl/core/cti_datapath.sv
rtl/core/cti_ctrl.sv
rtl/core/cubic_table_interpolator_to_plot_y.sv
tb/tb_cubic_table_interpolator_to_plot_y.sv
